FILE: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg - shared types and constants of the sbus frame decoder
// Channel geometry, scaling constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame geometry
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned RawW        = 11;
  localparam int unsigned ValW        = 12;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned DataBytes   = 22;
  localparam int unsigned PosW        = 5;
  localparam int unsigned StoreW      = MaxChannels * RawW;

  // scaling: ((raw * 5) >> 3) + offset
  localparam logic [ValW-1:0] ScaleOffset = 12'd880;

  // header qualification on the byte before the header
  localparam logic [7:0] PriorZero   = 8'h00;
  localparam logic [3:0] PriorNibble = 4'h4;

  // configuration register reset values
  localparam logic [7:0]        HeaderRst = 8'h0F;
  localparam logic [CountW-1:0] CountRst  = 5'd16;
  localparam logic [ValW-1:0]   MinRst    = 12'd1000;
  localparam logic [ValW-1:0]   MaxRst    = 12'd2000;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_COUNT  = 2'd1,
    CFG_MIN    = 2'd2,
    CFG_MAX    = 2'd3
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RECV  = 2'd0,
    ST_CHECK = 2'd1,
    ST_EMIT  = 2'd2
  } seq_state_e;

  // result of the shared scale and range unit
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            in_range;
  } scale_res_t;

endpackage

FILE: sv/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder - sbus frame decode with range check
// Hunts for a qualified header byte, collects 22 channel bytes and a flags
// byte, checks the scaled channels and emits a good frame as one run of words.
// ----------------------------------------------------------------------------
//
//  port group  | dir | word contents                         | handshake
//  ------------+-----+---------------------------------------+-------------
//  s_axis      | in  | tdata[7:0] rx_byte                    | tvalid/tready
//  m_axis      | out | tdata[3:0] index, [15:4] value, tlast | tvalid/tready
//  cfg         | in  | cfg_idx_i register, cfg_data_i value  | cfg_we_i
//
//  Bytes are taken back to back while receiving. The flags byte is followed
//  by a check pass of the shared scale unit over a 176-bit rotating channel
//  store, then by one word per emitted channel (channel count capped at 16),
//  each held until the sink takes it; a dropped frame emits no words.
//  s_axis_tready is low during the check pass and while words are emitted.
//  Reset clears the sequencer and header hunt state and returns the
//  configuration registers to their defaults.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // channel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] channel_index, [15:4] channel_value
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  localparam int unsigned StoreW = sfd_pkg::StoreW;
  localparam int unsigned RawW   = sfd_pkg::RawW;

  // configuration registers
  logic [7:0]                  header_q;
  logic [sfd_pkg::CountW-1:0]  count_q;
  logic [sfd_pkg::ValW-1:0]    min_q;
  logic [sfd_pkg::ValW-1:0]    max_q;

  // control state
  sfd_pkg::seq_state_e         state_q, state_d;
  logic                        in_frame_q, in_frame_d;
  logic [sfd_pkg::PosW-1:0]    pos_q, pos_d;
  logic [7:0]                  prior_q, prior_d;
  logic [sfd_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        ok_q, ok_d;

  // payload, flags keeps only the two bad-frame bits 3:2
  logic [StoreW-1:0]           store_q, store_d;
  logic [1:0]                  flags_q, flags_d;

  logic                        in_acc;
  logic                        out_acc;
  logic [sfd_pkg::CountW-1:0]  n_eff;
  logic                        idx_active;
  logic                        idx_last;
  logic                        hdr_hit;
  sfd_pkg::scale_res_t         unit_res;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // channel count saturates at the channel maximum
  assign n_eff = (count_q > sfd_pkg::CountW'(sfd_pkg::MaxChannels))
               ? sfd_pkg::CountW'(sfd_pkg::MaxChannels) : count_q;

  assign idx_active = ({1'b0, idx_q} < n_eff);
  assign idx_last   = (({1'b0, idx_q} + 5'd1) == n_eff);

  // header qualified by the byte that came before it
  assign hdr_hit = (s_axis_tdata == header_q) &&
                   ((prior_q == sfd_pkg::PriorZero) ||
                    (prior_q[3:0] == sfd_pkg::PriorNibble));

  // shared scale and compare unit, always on the lowest channel slot
  sfd_scale_unit u_scale (
    .raw_i (store_q[RawW-1:0]),
    .min_i (min_q),
    .max_i (max_q),
    .res_o (unit_res)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sfd_pkg::HeaderRst;
      count_q  <= sfd_pkg::CountRst;
      min_q    <= sfd_pkg::MinRst;
      max_q    <= sfd_pkg::MaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::CFG_HEADER: header_q <= cfg_data_i[7:0];
        sfd_pkg::CFG_COUNT:  count_q  <= cfg_data_i[sfd_pkg::CountW-1:0];
        sfd_pkg::CFG_MIN:    min_q    <= cfg_data_i;
        sfd_pkg::CFG_MAX:    max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sfd_pkg::ST_RECV;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      prior_q    <= '0;
      idx_q      <= '0;
      ok_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      prior_q    <= prior_d;
      idx_q      <= idx_d;
      ok_q       <= ok_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    flags_q <= flags_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    prior_d    = prior_q;
    idx_d      = idx_q;
    ok_d       = ok_q;
    store_d    = store_q;
    flags_d    = flags_q;

    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    case (state_q)
      sfd_pkg::ST_RECV: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          prior_d = s_axis_tdata;
          if (!in_frame_q) begin
            if (hdr_hit) begin
              in_frame_d = 1'b1;
              pos_d      = '0;
            end
          end else if (pos_q < sfd_pkg::PosW'(sfd_pkg::DataBytes)) begin
            // channel bytes shift in from the top, first byte ends lowest
            store_d = {s_axis_tdata, store_q[StoreW-1:8]};
            pos_d   = pos_q + 5'd1;
          end else begin
            // flags byte closes the frame
            flags_d    = s_axis_tdata[3:2];
            in_frame_d = 1'b0;
            pos_d      = '0;
            idx_d      = '0;
            ok_d       = 1'b1;
            state_d    = sfd_pkg::ST_CHECK;
          end
        end
      end

      sfd_pkg::ST_CHECK: begin
        // full turn of the store so the channels realign for emitting
        if (idx_active && !unit_res.in_range) begin
          ok_d = 1'b0;
        end
        store_d = {store_q[RawW-1:0], store_q[StoreW-1:RawW]};
        idx_d   = idx_q + 4'd1;
        if (idx_q == sfd_pkg::IdxW'(sfd_pkg::MaxChannels - 1)) begin
          if (ok_d && (flags_q == 2'b00) && (n_eff != '0)) begin
            state_d = sfd_pkg::ST_EMIT;
          end else begin
            state_d = sfd_pkg::ST_RECV;
          end
        end
      end

      sfd_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (out_acc) begin
          store_d = {store_q[RawW-1:0], store_q[StoreW-1:RawW]};
          idx_d   = idx_q + 4'd1;
          if (idx_last) begin
            idx_d   = '0;
            state_d = sfd_pkg::ST_RECV;
          end
        end
      end

      default: begin
        state_d = sfd_pkg::ST_RECV;
      end
    endcase
  end

  // output word
  assign m_axis_tdata = {unit_res.value, idx_q};
  assign m_axis_tlast = idx_last;

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a word is on the output");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> s_axis_tready)
    else $error("not back to receiving after the last word");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((unit_res.value >= min_q) && (unit_res.value <= max_q)))
    else $error("emitted value outside limits");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> idx_active)
    else $error("emitted index beyond channel count");

endmodule

FILE: sv/sfd_scale_unit.sv
// ----------------------------------------------------------------------------
// sfd_scale_unit - shared channel scale and range compare
// Scales one raw 11-bit channel to pulse width and checks it against limits.
// ----------------------------------------------------------------------------
module sfd_scale_unit (
  input  logic [sfd_pkg::RawW-1:0] raw_i,
  input  logic [sfd_pkg::ValW-1:0] min_i,
  input  logic [sfd_pkg::ValW-1:0] max_i,
  output sfd_pkg::scale_res_t      res_o
);

  logic [sfd_pkg::RawW+2:0] prod;
  logic [sfd_pkg::ValW-1:0] scaled;

  // raw * 5 as shift and add, then drop three bits and add offset
  assign prod   = {3'b000, raw_i} + {1'b0, raw_i, 2'b00};
  assign scaled = {1'b0, prod[sfd_pkg::RawW+2:3]} + sfd_pkg::ScaleOffset;

  // limit compare
  assign res_o.value    = scaled;
  assign res_o.in_range = (scaled >= min_i) && (scaled <= max_i);

endmodule
